FILE: rtl/core/ndp_pkg.sv
// ndp_pkg: types, phase codes and constants for the nit delivery descriptor parser
// depends on nothing; imported by nit_delivery_descriptor_parser
package ndp_pkg;

    // default section length limit in bytes
    localparam int MAX_SECTION_BYTES_DEF = 1024;

    // section header byte offsets, counted from table_id
    localparam int OFS_NET_HI = 3;
    localparam int OFS_NET_LO = 4;
    localparam int OFS_NLL_HI = 8;
    localparam int OFS_NLL_LO = 9;

    // descriptor tags
    localparam logic [7:0] TAG_NET_NAME  = 8'h40;
    localparam logic [7:0] TAG_SATELLITE = 8'h43;
    localparam logic [7:0] TAG_CABLE     = 8'h44;

    // delivery descriptor body length and index of the last stream entry header byte
    localparam int BODY_LEN      = 11;
    localparam int ENT_HDR_LAST  = 5;

    // result kinds
    localparam logic [1:0] KIND_CABLE     = 2'd0;
    localparam logic [1:0] KIND_SATELLITE = 2'd1;
    localparam logic [1:0] KIND_NAME_CHAR = 2'd2;

    // parser phase, one-hot
    typedef enum logic [11:0] {
        PH_IDLE     = 12'b0000_0000_0001,
        PH_HEADER   = 12'b0000_0000_0010,
        PH_NET_TAG  = 12'b0000_0000_0100,
        PH_NET_LEN  = 12'b0000_0000_1000,
        PH_NET_BODY = 12'b0000_0001_0000,
        PH_TSL_HI   = 12'b0000_0010_0000,
        PH_TSL_LO   = 12'b0000_0100_0000,
        PH_ENT_HDR  = 12'b0000_1000_0000,
        PH_ST_TAG   = 12'b0001_0000_0000,
        PH_ST_LEN   = 12'b0010_0000_0000,
        PH_ST_BODY  = 12'b0100_0000_0000,
        PH_DONE     = 12'b1000_0000_0000
    } phase_t;

endpackage

FILE: rtl/core/nit_delivery_descriptor_parser.sv
// nit_delivery_descriptor_parser: byte-wide NIT section walker that emits network name
// characters and cable / satellite delivery entries; depends on ndp_pkg
//
// The block takes one NIT section byte per transfer, starting at table_id (first_byte
// high), and can take a new byte in every cycle. A byte is taken into the input register;
// the parse stage then updates the loop counters and loads the output register, which
// presents the result for that byte. Throughput is one byte per cycle while the output
// side keeps up; a stalled output holds both stages.
// Bytes before any table_id, past the transport stream loop, or at offset
// MAX_SECTION_BYTES and beyond give no result. A delivery entry is produced on the
// eleventh body byte of a 0x43 or 0x44 descriptor; extra body bytes are skipped and
// shorter descriptors produce nothing.
module nit_delivery_descriptor_parser #(
    parameter int MAX_SECTION_BYTES = ndp_pkg::MAX_SECTION_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  section_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  entry_kind,
    output logic [15:0] network_id,
    output logic [15:0] stream_id,
    output logic [15:0] origin_network,
    output logic [31:0] frequency_bcd,
    output logic [15:0] orbit_bcd,
    output logic [7:0]  mode_byte,
    output logic [27:0] rate_bcd,
    output logic [3:0]  inner_fec,
    output logic [3:0]  outer_fec,
    output logic [6:0]  name_char
);
    import ndp_pkg::*;

    localparam int OFS_W = $clog2(MAX_SECTION_BYTES + 1);
    localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_SECTION_BYTES);
    localparam logic [3:0] CAP_LAST = 4'(BODY_LEN - 1);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_first_reg;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [OFS_W-1:0] offset_reg, offset_next;
    logic [11:0]      net_left_reg, net_left_next;
    logic [11:0]      sl_left_reg, sl_left_next;
    logic [11:0]      sd_left_reg, sd_left_next;
    logic [7:0]       desc_left_reg, desc_left_next;
    logic [7:0]       desc_tag_reg, desc_tag_next;
    logic [79:0]      cap_reg, cap_next;
    logic [3:0]       cap_cnt_reg, cap_cnt_next;
    logic [15:0]      held_net_reg, held_net_next;
    logic [15:0]      held_st_reg, held_st_next;
    logic [15:0]      held_org_reg, held_org_next;

    // result
    logic        emit;
    logic [1:0]  kind_c;
    logic [31:0] freq_c;
    logic [15:0] orbit_c, st_c, org_c;
    logic [7:0]  mode_c;
    logic [27:0] rate_c;
    logic [3:0]  inner_c, outer_c;
    logic [6:0]  char_c;

    logic        advance;
    logic        work;
    logic [7:0]  b;
    logic [11:0] net_dec, sl_dec, sd_dec;
    logic [7:0]  desc_dec;

    // pipeline flow: parse stage moves when the output register is free or being drained
    assign advance  = !out_valid || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign work     = s1_valid_reg && advance;
    assign b        = s1_byte_reg;

    assign net_dec  = net_left_reg - 12'd1;
    assign sl_dec   = sl_left_reg - 12'd1;
    assign sd_dec   = sd_left_reg - 12'd1;
    assign desc_dec = desc_left_reg - 8'd1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_byte_reg  <= '0;
            s1_first_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
            s1_byte_reg  <= section_byte;
            s1_first_reg <= first_byte;
        end
    end

    // parse one byte
    always_comb
    begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        net_left_next  = net_left_reg;
        sl_left_next   = sl_left_reg;
        sd_left_next   = sd_left_reg;
        desc_left_next = desc_left_reg;
        desc_tag_next  = desc_tag_reg;
        cap_next       = cap_reg;
        cap_cnt_next   = cap_cnt_reg;
        held_net_next  = held_net_reg;
        held_st_next   = held_st_reg;
        held_org_next  = held_org_reg;
        emit           = 1'b0;
        kind_c         = KIND_CABLE;
        freq_c         = '0;
        orbit_c        = '0;
        st_c           = '0;
        org_c          = '0;
        mode_c         = '0;
        rate_c         = '0;
        inner_c        = '0;
        outer_c        = '0;
        char_c         = '0;

        if (work && s1_first_reg)
        begin
            // table_id restarts the section from scratch
            phase_next     = PH_HEADER;
            offset_next    = OFS_W'(1);
            net_left_next  = '0;
            sl_left_next   = '0;
            sd_left_next   = '0;
            desc_left_next = '0;
            desc_tag_next  = '0;
            cap_next       = '0;
            cap_cnt_next   = '0;
            held_net_next  = '0;
            held_st_next   = '0;
            held_org_next  = '0;
        end
        else if (work && phase_reg != PH_IDLE && phase_reg != PH_DONE)
        begin
            if (offset_reg >= OFS_MAX)
            begin
                // section too long
                phase_next = PH_DONE;
            end
            else
            begin
                offset_next = offset_reg + OFS_W'(1);
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (offset_reg == OFS_W'(OFS_NET_HI))
                            held_net_next = {b, 8'h00};
                        else if (offset_reg == OFS_W'(OFS_NET_LO))
                            held_net_next = held_net_reg | {8'h00, b};
                        else if (offset_reg == OFS_W'(OFS_NLL_HI))
                            net_left_next = {b[3:0], 8'h00};
                        else if (offset_reg == OFS_W'(OFS_NLL_LO))
                        begin
                            net_left_next = net_left_reg | {4'h0, b};
                            phase_next = ((net_left_reg | {4'h0, b}) == 12'd0) ?
                                         PH_TSL_HI : PH_NET_TAG;
                        end
                    end
                    PH_NET_TAG:
                    begin
                        desc_tag_next = b;
                        net_left_next = net_dec;
                        phase_next    = (net_dec == 12'd0) ? PH_TSL_HI : PH_NET_LEN;
                    end
                    PH_NET_LEN:
                    begin
                        desc_left_next = b;
                        net_left_next  = net_dec;
                        if (net_dec == 12'd0)
                            phase_next = PH_TSL_HI;
                        else if (b == 8'd0)
                            phase_next = PH_NET_TAG;
                        else
                            phase_next = PH_NET_BODY;
                    end
                    PH_NET_BODY:
                    begin
                        desc_left_next = desc_dec;
                        net_left_next  = net_dec;
                        // network name character, nul and high-bit bytes dropped
                        if (desc_tag_reg == TAG_NET_NAME && b != 8'd0 && !b[7])
                        begin
                            emit   = 1'b1;
                            kind_c = KIND_NAME_CHAR;
                            char_c = b[6:0];
                        end
                        if (net_dec == 12'd0)
                            phase_next = PH_TSL_HI;
                        else if (desc_dec == 8'd0)
                            phase_next = PH_NET_TAG;
                        else
                            phase_next = PH_NET_BODY;
                    end
                    PH_TSL_HI:
                    begin
                        sl_left_next = {b[3:0], 8'h00};
                        phase_next   = PH_TSL_LO;
                    end
                    PH_TSL_LO:
                    begin
                        sl_left_next = sl_left_reg | {4'h0, b};
                        if ((sl_left_reg | {4'h0, b}) == 12'd0)
                            phase_next = PH_DONE;
                        else
                        begin
                            phase_next     = PH_ENT_HDR;
                            desc_left_next = '0;
                        end
                    end
                    PH_ENT_HDR:
                    begin
                        // six-byte stream entry header, desc_left counts its bytes
                        sl_left_next = sl_dec;
                        case (desc_left_reg)
                            8'd0:    held_st_next  = {b, 8'h00};
                            8'd1:    held_st_next  = held_st_reg | {8'h00, b};
                            8'd2:    held_org_next = {b, 8'h00};
                            8'd3:    held_org_next = held_org_reg | {8'h00, b};
                            8'd4:    sd_left_next  = {b[3:0], 8'h00};
                            default: sd_left_next  = sd_left_reg | {4'h0, b};
                        endcase
                        if (sl_dec == 12'd0)
                            phase_next = PH_DONE;
                        else if (desc_left_reg >= 8'(ENT_HDR_LAST))
                        begin
                            desc_left_next = '0;
                            phase_next = ((sd_left_reg | {4'h0, b}) == 12'd0) ?
                                         PH_ENT_HDR : PH_ST_TAG;
                        end
                        else
                            desc_left_next = desc_left_reg + 8'd1;
                    end
                    PH_ST_TAG:
                    begin
                        desc_tag_next = b;
                        cap_cnt_next  = '0;
                        sl_left_next  = sl_dec;
                        sd_left_next  = sd_dec;
                        if (sl_dec == 12'd0)
                            phase_next = PH_DONE;
                        else if (sd_dec == 12'd0)
                        begin
                            phase_next     = PH_ENT_HDR;
                            desc_left_next = '0;
                        end
                        else
                            phase_next = PH_ST_LEN;
                    end
                    PH_ST_LEN:
                    begin
                        desc_left_next = b;
                        sl_left_next   = sl_dec;
                        sd_left_next   = sd_dec;
                        if (sl_dec == 12'd0)
                            phase_next = PH_DONE;
                        else if (sd_dec == 12'd0)
                        begin
                            phase_next     = PH_ENT_HDR;
                            desc_left_next = '0;
                        end
                        else if (b == 8'd0)
                            phase_next = PH_ST_TAG;
                        else
                            phase_next = PH_ST_BODY;
                    end
                    PH_ST_BODY:
                    begin
                        desc_left_next = desc_dec;
                        sl_left_next   = sl_dec;
                        sd_left_next   = sd_dec;
                        // capture body bytes; the eleventh completes a delivery entry
                        if (cap_cnt_reg < 4'(BODY_LEN))
                        begin
                            cap_next     = {cap_reg[71:0], b};
                            cap_cnt_next = cap_cnt_reg + 4'd1;
                            if (cap_cnt_reg == CAP_LAST &&
                                (desc_tag_reg == TAG_SATELLITE || desc_tag_reg == TAG_CABLE))
                            begin
                                emit    = 1'b1;
                                st_c    = held_st_reg;
                                org_c   = held_org_reg;
                                freq_c  = cap_reg[79:48];
                                mode_c  = cap_reg[31:24];
                                rate_c  = {cap_reg[23:0], b[7:4]};
                                inner_c = b[3:0];
                                if (desc_tag_reg == TAG_SATELLITE)
                                begin
                                    kind_c  = KIND_SATELLITE;
                                    orbit_c = cap_reg[47:32];
                                end
                                else
                                begin
                                    kind_c  = KIND_CABLE;
                                    outer_c = cap_reg[35:32];
                                end
                            end
                        end
                        if (sl_dec == 12'd0)
                            phase_next = PH_DONE;
                        else if (sd_dec == 12'd0)
                        begin
                            phase_next     = PH_ENT_HDR;
                            desc_left_next = '0;
                        end
                        else if (desc_dec == 8'd0)
                            phase_next = PH_ST_TAG;
                        else
                            phase_next = PH_ST_BODY;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            offset_reg    <= '0;
            net_left_reg  <= '0;
            sl_left_reg   <= '0;
            sd_left_reg   <= '0;
            desc_left_reg <= '0;
            desc_tag_reg  <= '0;
            cap_reg       <= '0;
            cap_cnt_reg   <= '0;
            held_net_reg  <= '0;
            held_st_reg   <= '0;
            held_org_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            net_left_reg  <= net_left_next;
            sl_left_reg   <= sl_left_next;
            sd_left_reg   <= sd_left_next;
            desc_left_reg <= desc_left_next;
            desc_tag_reg  <= desc_tag_next;
            cap_reg       <= cap_next;
            cap_cnt_reg   <= cap_cnt_next;
            held_net_reg  <= held_net_next;
            held_st_reg   <= held_st_next;
            held_org_reg  <= held_org_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (advance)
            out_valid <= work && emit;
    end

    always_ff @(posedge clk)
    begin
        if (work && emit)
        begin
            entry_kind     <= kind_c;
            network_id     <= held_net_reg;
            stream_id      <= st_c;
            origin_network <= org_c;
            frequency_bcd  <= freq_c;
            orbit_bcd      <= orbit_c;
            mode_byte      <= mode_c;
            rate_bcd       <= rate_c;
            inner_fec      <= inner_c;
            outer_fec      <= outer_c;
            name_char      <= char_c;
        end
    end

    // capture count never runs past the body length
    assert property (@(posedge clk) disable iff (!rst_n)
        cap_cnt_reg <= 4'(BODY_LEN))
        else $error("capture count beyond body length");

    // byte offset stops at the section limit
    assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= OFS_MAX)
        else $error("byte offset beyond section limit");

    // a table_id transfer leaves the parser in the header phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (work && s1_first_reg) |=> (phase_reg == PH_HEADER && offset_reg == OFS_W'(1)))
        else $error("table_id did not restart the section");

    // a result never carries an unused kind code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_kind == KIND_CABLE || entry_kind == KIND_SATELLITE ||
                       entry_kind == KIND_NAME_CHAR))
        else $error("bad entry kind");

    // a name character result leaves the delivery fields clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && entry_kind == KIND_NAME_CHAR) |->
            (stream_id == 16'd0 && frequency_bcd == 32'd0 && rate_bcd == 28'd0))
        else $error("name character with delivery fields");

endmodule
